@@ hw/rtl/gb3_pkg.sv @@
// Shared constants and types for the 3x3 Gaussian blur block.
`default_nettype none

package gb3_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int ROW_REG_W  = 13;
    localparam int COL_REG_W  = 11;
    localparam int CFG_DATA_W = ROW_REG_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // Smallest legal frame dimension
    localparam int MIN_DIM = 3;

    // Kernel weights sum to 16
    localparam int KERNEL_SHIFT = 4;

    // Entries between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

    // Per-item classification made by the front
    typedef struct packed {
        logic emit;    // item produces a result
        logic border;  // result lies on the frame border
        logic last;    // result is the final one of the frame
    } t_item_flags;

endpackage

`default_nettype wire

@@ hw/rtl/gb3_stream_if.sv @@
// Valid/ready stream channel carrying one packed payload.
`default_nettype none

interface gb3_stream_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gb3_ram.sv @@
// Generic simple dual-port RAM with registered read (read-before-write).
`default_nettype none

module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ hw/rtl/gb3_queue.sv @@
// Small register FIFO between the front and back halves.
`default_nettype none

module gb3_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [W-1:0]               i_data,
    input  wire logic                       i_pop,
    output      logic                       o_valid,
    output      logic [W-1:0]               o_data,
    output      logic [$clog2(DEPTH+1)-1:0] o_level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_count;
endmodule

`default_nettype wire

@@ hw/rtl/gb3_front.sv @@
// Front half: configuration, raster counters, item classification, line buffers.
`default_nettype none

module gb3_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output      logic                             o_ready,
    input  wire logic                             i_kind,
    input  wire logic [PIXEL_BITS-1:0]            i_pixel,
    input  wire logic [gb3_pkg::QLEVEL_W-1:0]     i_q_level,
    output      logic                             o_push,
    output      logic [$bits(gb3_pkg::t_item_flags)+3*PIXEL_BITS-1:0] o_push_data
);
    import gb3_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int RIN_W  = $clog2(MAX_ROWS + 2);

    logic [RCNT_W-1:0] r_rows;
    logic [CCNT_W-1:0] r_cols;
    logic [RIN_W-1:0]  r_in_row, n_in_row;
    logic [CCNT_W-1:0] r_in_col, n_in_col;
    logic [RCNT_W-1:0] r_out_row, n_out_row;
    logic [CCNT_W-1:0] r_out_col, n_out_col;

    logic [31:0]       cfg_row_val, cfg_col_val;
    logic [RCNT_W-1:0] rows_clamped;
    logic [CCNT_W-1:0] cols_clamped;

    logic              accept, ignore, take;
    logic [PIXEL_BITS-1:0] pix_val;
    t_item_flags       flags;
    logic              in_col_last, out_row_last, out_col_last;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    t_item_flags       r_s1_flags;
    logic [PIXEL_BITS-1:0] above_rdata, two_rdata;

    // Clamp written dimensions into the legal range
    always_comb begin
        cfg_row_val = 32'(i_cfg_data[ROW_REG_W-1:0]);
        cfg_col_val = 32'(i_cfg_data[COL_REG_W-1:0]);
        if (cfg_row_val < 32'(MIN_DIM)) begin
            rows_clamped = RCNT_W'(MIN_DIM);
        end else if (cfg_row_val > 32'(MAX_ROWS)) begin
            rows_clamped = RCNT_W'(MAX_ROWS);
        end else begin
            rows_clamped = RCNT_W'(cfg_row_val);
        end
        if (cfg_col_val < 32'(MIN_DIM)) begin
            cols_clamped = CCNT_W'(MIN_DIM);
        end else if (cfg_col_val > 32'(MAX_COLS)) begin
            cols_clamped = CCNT_W'(MAX_COLS);
        end else begin
            cols_clamped = CCNT_W'(cfg_col_val);
        end
    end

    // Room must remain for the item still waiting on the line buffer read
    assign o_ready = ({1'b0, i_q_level} + {{QLEVEL_W{1'b0}}, r_s1_valid})
                     < (QLEVEL_W + 1)'(QUEUE_DEPTH);

    assign accept  = i_valid && o_ready;
    // Flush before any pixel of a frame: drop
    assign ignore  = i_kind && (r_in_row == '0) && (r_in_col == '0);
    assign take    = accept && !ignore;
    assign pix_val = i_kind ? '0 : i_pixel;

    always_comb begin
        in_col_last  = (r_in_col == r_cols - 1'b1);
        out_row_last = (r_out_row == r_rows - 1'b1);
        out_col_last = (r_out_col == r_cols - 1'b1);

        flags.emit   = (r_in_row >= RIN_W'(2)) ||
                       ((r_in_row == RIN_W'(1)) && (r_in_col != '0));
        flags.border = (r_out_row == '0) || out_row_last ||
                       (r_out_col == '0) || out_col_last;
        flags.last   = out_row_last && out_col_last;

        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;

        if (take) begin
            if (flags.emit && flags.last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                if (in_col_last) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (flags.emit) begin
                    if (out_col_last) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= RCNT_W'(MIN_DIM);
            r_cols     <= CCNT_W'(MIN_DIM);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_ROW_COUNT: r_rows <= rows_clamped;
                    REG_COL_COUNT: r_cols <= cols_clamped;
                    default:       r_rows <= r_rows;
                endcase
                // Any write restarts the frame
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                r_in_row  <= n_in_row;
                r_in_col  <= n_in_col;
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_col   <= r_in_col[COL_W-1:0];
            r_s1_pix   <= pix_val;
            r_s1_flags <= flags;
        end
    end

    // Line above: read the old value and store the new pixel in the same cycle
    gb3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (r_in_col[COL_W-1:0]),
        .i_wdata (pix_val),
        .i_raddr (r_in_col[COL_W-1:0]),
        .o_rdata (above_rdata)
    );

    // Line two above: takes the displaced line-above value in the following cycle
    gb3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (above_rdata),
        .i_raddr (r_in_col[COL_W-1:0]),
        .o_rdata (two_rdata)
    );

    assign o_push      = r_s1_valid;
    assign o_push_data = {r_s1_flags, two_rdata, above_rdata, r_s1_pix};
endmodule

`default_nettype wire

@@ hw/rtl/gb3_back.sv @@
// Back half: 3x3 window, weighted sum and output register.
`default_nettype none

module gb3_back #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire logic [$bits(gb3_pkg::t_item_flags)+3*PIXEL_BITS-1:0] i_q_data,
    output      logic                         o_q_pop,
    output      logic                         o_valid,
    input  wire logic                         i_ready,
    output      logic [PIXEL_BITS-1:0]        o_filtered,
    output      logic                         o_last
);
    import gb3_pkg::*;

    localparam int SUM_W = PIXEL_BITS + KERNEL_SHIFT;

    t_item_flags           q_flags;
    logic [PIXEL_BITS-1:0] q_top, q_mid, q_new;

    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic                  r_w_valid;
    t_item_flags           r_w_flags;
    logic                  w_move;

    logic [SUM_W-1:0]      sum;
    logic [PIXEL_BITS-1:0] blur;

    logic                  r_o_valid;
    logic [PIXEL_BITS-1:0] r_o_pix;
    logic                  r_o_last;

    assign {q_flags, q_top, q_mid, q_new} = i_q_data;

    // Window item leaves when it has no result or the output register frees
    assign w_move  = r_w_valid && (!r_w_flags.emit || !r_o_valid || i_ready);
    assign o_q_pop = i_q_valid && (!r_w_valid || w_move);

    always_comb begin
        sum =  SUM_W'(r_win[0][0])         + (SUM_W'(r_win[0][1]) << 1)
             + SUM_W'(r_win[0][2])         + (SUM_W'(r_win[1][0]) << 1)
             + (SUM_W'(r_win[1][1]) << 2)  + (SUM_W'(r_win[1][2]) << 1)
             + SUM_W'(r_win[2][0])         + (SUM_W'(r_win[2][1]) << 1)
             + SUM_W'(r_win[2][2]);
        blur = r_w_flags.border ? '0 : sum[SUM_W-1:KERNEL_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_w_valid <= 1'b1;
            end else if (w_move) begin
                r_w_valid <= 1'b0;
            end
            if (w_move && r_w_flags.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Shift the window left and load the new column
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= q_top;
            r_win[1][2] <= q_mid;
            r_win[2][2] <= q_new;
            r_w_flags   <= q_flags;
        end
        if (w_move && r_w_flags.emit) begin
            r_o_pix  <= blur;
            r_o_last <= r_w_flags.last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_o_pix;
    assign o_last     = r_o_last;
endmodule

`default_nettype wire

@@ hw/rtl/gaussian_blur_3x3.sv @@
// Top level of the streaming 3x3 Gaussian blur.
//
//  channel   dir  payload (msb..lsb)            transfer
//  i_pix     in   {kind, pixel[PIXEL_BITS-1:0]}  valid && ready
//  o_blur    out  {last, filtered[PIXEL_BITS-1:0]} valid && ready
//  i_cfg_*   in   index, data                    i_cfg_wr_en
//
// Takes one item per clock while the queue has room; a result passes the line buffer
// read, the queue, the window stage and the output register after its item is taken.
// Reset sets 3x3 frames and clears all counters; line buffers are not cleared.
// A four-entry queue parts the front from the window stage, so a stalled
// output keeps the front taking items until the queue fills.
`default_nettype none

module gaussian_blur_3x3 #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    gb3_stream_if.sink                          i_pix,
    gb3_stream_if.source                        o_blur,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gb3_pkg::*;

    localparam int ITEM_W = $bits(t_item_flags) + 3 * PIXEL_BITS;

    logic              push, pop, q_valid;
    logic [ITEM_W-1:0] push_data, q_data;
    logic [QLEVEL_W-1:0] q_level;
    logic [PIXEL_BITS-1:0] filtered;
    logic              last;

    gb3_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_kind      (i_pix.data[PIXEL_BITS]),
        .i_pixel     (i_pix.data[PIXEL_BITS-1:0]),
        .i_q_level   (q_level),
        .o_push      (push),
        .o_push_data (push_data)
    );

    gb3_queue #(
        .W     (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_level (q_level)
    );

    gb3_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (pop),
        .o_valid    (o_blur.valid),
        .i_ready    (o_blur.ready),
        .o_filtered (filtered),
        .o_last     (last)
    );

    assign o_blur.data = {last, filtered};
endmodule

`default_nettype wire

@@ verif/tb_gaussian_blur_3x3.sv @@
// Self-checking testbench for the streaming 3x3 Gaussian blur block.
`default_nettype none

module tb_gaussian_blur_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import gb3_pkg::*;

    localparam int MAX_COLS       = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int PIX_W          = 8;
    localparam int ITEM_W         = PIX_W + 1;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 14;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 800;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } t_pix_item;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] filtered;
    } t_blur_result;

    typedef enum logic [1:0] {
        STYLE_NOISE, STYLE_BINARY, STYLE_RAMP, STYLE_STRIPES
    } t_pix_style;
    typedef enum logic [1:0] {SEQ_CLEAN, SEQ_CUT, SEQ_MESSY} t_seq_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gb3_stream_if #(.W(ITEM_W)) pix_if ();
    gb3_stream_if #(.W(ITEM_W)) blur_if ();

    gaussian_blur_3x3 #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIX_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_blur      (blur_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Blur predictor state
    logic [PIX_W-1:0] row_above_buf [MAX_COLS];
    logic [PIX_W-1:0] row_two_above_buf [MAX_COLS];
    logic [PIX_W-1:0] blur_win [3][3];
    int unsigned      pos_row, pos_col, out_count;
    int unsigned      frame_rows, frame_cols;

    t_pix_item    pixel_feed_q [$];
    t_blur_result pending_blur_q [$];

    int send_max_gap, recv_max_gap;
    int send_wait, recv_wait, recv_next_wait;
    int hold_cycles_req, hold_left;
    logic hold_taken;
    int stall_cycles;
    int error_count, in_transfers, results_checked, frames_done, queued_items;
    t_blur_result mon_got, mon_want;

    // Advance the frame model by one accepted item; queue the pixel it yields, if any.
    task automatic advance_blur_model(input t_pix_item item);
        logic [PIX_W-1:0] v;
        int unsigned      col, pr, pc, sum;
        logic             emit;
        t_blur_result     res;
        int               k;
        v   = (item.kind == KIND_FLUSH) ? '0 : item.pixel;
        col = pos_col;
        // drop a flush that arrives with no frame in progress
        if (item.kind == KIND_FLUSH && pos_row == 0 && pos_col == 0) return;
        for (k = 0; k < 3; k++) begin
            blur_win[k][0] = blur_win[k][1];
            blur_win[k][1] = blur_win[k][2];
        end
        blur_win[0][2]         = row_two_above_buf[col];
        blur_win[1][2]         = row_above_buf[col];
        blur_win[2][2]         = v;
        row_two_above_buf[col] = row_above_buf[col];
        row_above_buf[col]     = v;
        emit = (pos_row >= 2) || (pos_row == 1 && pos_col >= 1);
        pos_col++;
        if (pos_col >= frame_cols) begin
            pos_col = 0;
            pos_row++;
        end
        if (!emit) return;
        pr = out_count / frame_cols;
        pc = out_count % frame_cols;
        res.filtered = '0;
        if (pr >= 1 && pr + 1 < frame_rows && pc >= 1 && pc + 1 < frame_cols) begin
            sum = blur_win[0][0] + 2 * blur_win[0][1] + blur_win[0][2]
                + 2 * blur_win[1][0] + 4 * blur_win[1][1] + 2 * blur_win[1][2]
                + blur_win[2][0] + 2 * blur_win[2][1] + blur_win[2][2];
            res.filtered = PIX_W'(sum >> KERNEL_SHIFT);
        end
        out_count++;
        res.last = (out_count >= frame_rows * frame_cols);
        if (res.last) begin
            pos_row   = 0;
            pos_col   = 0;
            out_count = 0;
        end
        pending_blur_q.push_back(res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        int unsigned v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ROW_COUNT) begin
            v = value;
            frame_rows = (v < MIN_DIM) ? MIN_DIM : (v > MAX_ROWS) ? MAX_ROWS : v;
        end else begin
            v = value[COL_REG_W-1:0];
            frame_cols = (v < MIN_DIM) ? MIN_DIM : (v > MAX_COLS) ? MAX_COLS : v;
        end
        pos_row   = 0;
        pos_col   = 0;
        out_count = 0;
    endtask

    // Column writes carry random bits above the register width; they must be dropped.
    task automatic set_frame(input int rows, input int cols);
        int unsigned upper;
        upper = $urandom_range(0, 3);
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(REG_COL_COUNT, CFG_DATA_W'(cols | (upper << COL_REG_W)));
    endtask

    task automatic push_item(input logic kind, input logic [PIX_W-1:0] pixel);
        t_pix_item item;
        item.kind  = kind;
        item.pixel = pixel;
        pixel_feed_q.push_back(item);
        queued_items++;
    endtask

    function automatic logic [PIX_W-1:0] gen_pixel(input t_pix_style style, input int r,
                                                   input int c);
        case (style)
            STYLE_BINARY:  return $urandom_range(0, 1) ? '1 : '0;
            STYLE_RAMP:    return PIX_W'(r * 17 + c * 9 + $urandom_range(0, 7));
            STYLE_STRIPES: return ((r + c) & 1) ? '1 : PIX_W'($urandom_range(0, 15));
            default:       return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_frame(input int rows, input int cols, input t_pix_style style);
        int r, c;
        for (r = 0; r < rows; r++)
            for (c = 0; c < cols; c++)
                push_item(KIND_PIXEL, gen_pixel(style, r, c));
        for (c = 0; c <= cols; c++)
            push_item(KIND_FLUSH, PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pixel_feed_q.size() != 0 || pix_if.valid || pending_blur_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender: one item in flight, random gap before each new item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            send_wait    <= 0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pix_if.valid) begin
                advance_blur_model(t_pix_item'(pix_if.data));
                in_transfers++;
            end
            if (send_wait > 0) begin
                pix_if.valid <= 1'b0;
                send_wait    <= send_wait - 1;
            end else if (pixel_feed_q.size() != 0) begin
                pix_if.valid <= 1'b1;
                pix_if.data  <= pixel_feed_q.pop_front();
                send_wait    <= $urandom_range(0, send_max_gap);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer, then stall a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blur_if.ready <= 1'b0;
            recv_wait     <= 0;
            hold_left     <= 0;
            hold_taken    <= 1'b0;
        end else begin
            if (blur_if.valid && blur_if.ready) begin
                mon_got = t_blur_result'(blur_if.data);
                if (pending_blur_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d last=%0d",
                             $realtime, mon_got.filtered, mon_got.last);
                end else begin
                    mon_want = pending_blur_q.pop_front();
                    if (mon_got.filtered !== mon_want.filtered) begin
                        error_count++;
                        $display("%0t: filtered mismatch, expected %0d actual %0d",
                                 $realtime, mon_want.filtered, mon_got.filtered);
                    end
                    if (mon_got.last !== mon_want.last) begin
                        error_count++;
                        $display("%0t: last mismatch, expected %0d actual %0d",
                                 $realtime, mon_want.last, mon_got.last);
                    end
                    results_checked++;
                    if (mon_want.last) frames_done++;
                end
            end
            if (hold_cycles_req != 0 && !hold_taken) begin
                hold_taken    <= 1'b1;
                hold_left     <= hold_cycles_req;
                blur_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                blur_if.ready <= 1'b0;
            end else if (blur_if.valid && blur_if.ready) begin
                recv_next_wait = $urandom_range(0, recv_max_gap);
                recv_wait     <= recv_next_wait;
                blur_if.ready <= (recv_next_wait == 0);
            end else if (recv_wait > 0) begin
                recv_wait     <= recv_wait - 1;
                blur_if.ready <= (recv_wait == 1);
            end else begin
                blur_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (blur_if.valid && blur_if.ready)
                || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, stall_cycles);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int         rows, cols, n, i, r, c, start_items;
        t_seq_shape shape;
        t_pix_style style;
        t_pix_item  noise;

        i_rst_n         = 1'b0;
        pix_if.valid    = 1'b0;
        pix_if.data     = '0;
        blur_if.ready   = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        send_max_gap    = MAX_GAP;
        recv_max_gap    = MAX_GAP;
        hold_cycles_req = 0;
        stall_cycles    = 0;
        error_count     = 0;
        in_transfers    = 0;
        results_checked = 0;
        frames_done     = 0;
        queued_items    = 0;
        frame_rows      = MIN_DIM;
        frame_cols      = MIN_DIM;
        pos_row         = 0;
        pos_col         = 0;
        out_count       = 0;
        for (i = 0; i < MAX_COLS; i++) begin
            row_above_buf[i]     = '0;
            row_two_above_buf[i] = '0;
        end
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                blur_win[r][c] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes (3x3): stray flush, bright center, flush inside the frame,
        // pixel during the drain, then a saturated frame.
        push_item(KIND_FLUSH, 8'hA5);
        for (i = 0; i < 8; i++)
            push_item(KIND_PIXEL, (i == 4) ? 8'hFF : 8'h00);
        push_item(KIND_FLUSH, 8'hFF);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_PIXEL, 8'h5A);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_FLUSH, 8'hFF);
        for (i = 0; i < 9; i++)
            push_item(KIND_PIXEL, 8'hFF);
        for (i = 0; i < 4; i++)
            push_item(KIND_FLUSH, 8'h00);
        wait_idle();

        // Out-of-range writes clamp to the smallest frame
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, CFG_DATA_W'(2));
        queue_frame(3, 3, STYLE_BINARY);
        wait_idle();

        // Tallest frame, cut short
        write_reg(REG_ROW_COUNT, '1);
        write_reg(REG_COL_COUNT, '0);
        for (i = 0; i < 40; i++)
            push_item(KIND_PIXEL, gen_pixel(STYLE_NOISE, i / 3, i % 3));
        wait_idle();

        // Widest frame, cut short before its first result
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, '1);
        for (i = 0; i < 48; i++)
            push_item(KIND_PIXEL, gen_pixel(STYLE_RAMP, 0, i));
        wait_idle();

        // Hold the output off while the input keeps offering, so the block backs up
        send_max_gap = 0;
        recv_max_gap = 0;
        set_frame(6, 10);
        @(negedge i_clk);
        hold_cycles_req = HOLD_CYCLES;
        queue_frame(6, 10, STYLE_NOISE);
        wait_idle();

        start_items = queued_items;
        while (queued_items - start_items < RANDOM_ITEMS) begin
            send_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            recv_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if ($urandom_range(0, 7) == 0) begin
                rows = $urandom_range(3, 4);
                cols = $urandom_range(13, 64);
            end else begin
                rows = $urandom_range(3, 8);
                cols = $urandom_range(3, 12);
            end
            set_frame(rows, cols);
            style = t_pix_style'($urandom_range(0, 3));
            n     = $urandom_range(0, 9);
            shape = (n == 0) ? SEQ_CUT : (n == 1) ? SEQ_MESSY : SEQ_CLEAN;
            case (shape)
                SEQ_CUT: begin
                    n = $urandom_range(1, rows * cols + cols);
                    for (i = 0; i < n; i++)
                        push_item(KIND_PIXEL, gen_pixel(style, i / cols, i % cols));
                end
                SEQ_MESSY: begin
                    // stray flushes first; these are dropped and not counted
                    n = $urandom_range(0, 3);
                    for (i = 0; i < n; i++) begin
                        noise.kind  = KIND_FLUSH;
                        noise.pixel = PIX_W'($urandom_range(0, 255));
                        pixel_feed_q.push_back(noise);
                    end
                    for (r = 0; r < rows; r++)
                        for (c = 0; c < cols; c++)
                            push_item(($urandom_range(0, 15) == 0) ? KIND_FLUSH : KIND_PIXEL,
                                      gen_pixel(style, r, c));
                    n = $urandom_range(0, cols + 3);
                    for (i = 0; i < n; i++)
                        push_item(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
                end
                default: begin
                    n = $urandom_range(1, 2);
                    for (i = 0; i < n; i++)
                        queue_frame(rows, cols, style);
                end
            endcase
            wait_idle();
        end

        $display("covered %0d input transfers and %0d checked results over %0d whole frames",
                 in_transfers, results_checked, frames_done);
        $display("frames from 3x3 up to 8x64, clamped tallest and widest sizes, stalls on both sides");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/gb3_pkg.sv
hw/rtl/gb3_stream_if.sv
hw/rtl/gb3_ram.sv
hw/rtl/gb3_queue.sv
hw/rtl/gb3_front.sv
hw/rtl/gb3_back.sv
hw/rtl/gaussian_blur_3x3.sv
verif/tb_gaussian_blur_3x3.sv
